FILE: rtl/sd_spi_init_sequencer_assert.svh
// Assertion macros used by the SD SPI init sequencer core.
`ifndef SD_SPI_INIT_SEQUENCER_ASSERT_SVH
`define SD_SPI_INIT_SEQUENCER_ASSERT_SVH

`ifndef SYNTH

// Property holds at every clock edge outside reset.
`define SDSI_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("sdsi assertion failed");

// Condition a in one cycle implies condition b in the next.
`define SDSI_ASSERT_NEXT(lbl, clk, rst_n, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("sdsi assertion failed");

`else

`define SDSI_ASSERT(lbl, clk, rst_n, prop)
`define SDSI_ASSERT_NEXT(lbl, clk, rst_n, a, b)

`endif

`endif

FILE: rtl/sdsi_pkg.sv
// Types, constants and command byte table for the SD SPI init sequencer.
package sdsi_pkg;

	// input beat
	typedef struct packed {
		logic       action;
		logic [7:0] rx_byte;
	} item_t;

	// result beat
	typedef struct packed {
		logic [7:0] tx_byte;
		logic       cs_level;
		logic       busy_res;
		logic       done_res;
		logic [2:0] error_code;
		logic       hi_cap;
	} result_t;

	localparam int unsigned CFG_W     = 16;
	localparam int unsigned CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_POLL_LIMIT  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RETRY_LIMIT = 1'd1;
	localparam logic [15:0] POLL_LIMIT_RST  = 16'd1000;
	localparam logic [15:0] RETRY_LIMIT_RST = 16'd1000;

	// input action codes
	localparam logic ACT_START = 1'b0;
	localparam logic ACT_BYTE  = 1'b1;

	// command stages
	localparam logic [2:0] ST_CMD0   = 3'd0;
	localparam logic [2:0] ST_CMD8   = 3'd1;
	localparam logic [2:0] ST_CMD58  = 3'd2;
	localparam logic [2:0] ST_CMD55  = 3'd3;
	localparam logic [2:0] ST_ACMD41 = 3'd4;
	localparam logic [2:0] ST_FINAL  = 3'd5;

	// error codes
	localparam logic [2:0] ERR_OK       = 3'd0;
	localparam logic [2:0] ERR_CMD0     = 3'd1;
	localparam logic [2:0] ERR_CMD8     = 3'd2;
	localparam logic [2:0] ERR_CMD8_ILL = 3'd3;
	localparam logic [2:0] ERR_CMD58    = 3'd4;
	localparam logic [2:0] ERR_TIMEOUT  = 3'd5;
	localparam logic [2:0] ERR_STD_CAP  = 3'd6;
	localparam logic [2:0] ERR_NO_CARD  = 3'd7;

	localparam logic [7:0]  IDLE_BYTE  = 8'hFF;
	localparam logic [7:0]  CMD_START  = 8'h40;
	localparam logic [7:0]  CRC_CMD0   = 8'h95;
	localparam logic [7:0]  CRC_CMD8   = 8'h87;
	localparam logic [7:0]  CRC_OTHER  = 8'h01;
	localparam logic [31:0] ARG_CMD8   = 32'h0000_01AA;
	localparam logic [31:0] ARG_ACMD41 = 32'h4000_0000;

	// byte k of the six-byte command frame for a stage
	function automatic logic [7:0] cmd_byte(input logic [2:0] st, input logic [2:0] k);
		logic [31:0] arg;
		logic [7:0]  idx;
		logic [7:0]  crc;
		logic [7:0]  b;
		arg = 32'h0;
		crc = CRC_OTHER;
		unique case (st)
			ST_CMD0: begin
				idx = 8'd0;
				crc = CRC_CMD0;
			end
			ST_CMD8: begin
				idx = 8'd8;
				arg = ARG_CMD8;
				crc = CRC_CMD8;
			end
			ST_CMD55:  idx = 8'd55;
			ST_ACMD41: begin
				idx = 8'd41;
				arg = ARG_ACMD41;
			end
			default:   idx = 8'd58;
		endcase
		unique case (k)
			3'd0:    b = CMD_START | idx;
			3'd1:    b = arg[31:24];
			3'd2:    b = arg[23:16];
			3'd3:    b = arg[15:8];
			3'd4:    b = arg[7:0];
			default: b = crc;
		endcase
		return b;
	endfunction

endpackage

FILE: rtl/sdsi_in_reg.sv
// Input register stage: holds one accepted beat until the core takes it.
module sdsi_in_reg import sdsi_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  item_t in_item,
	input  logic  take,
	output logic  item_valid,
	output item_t item
);

	logic  valid_s1;
	item_t item_s1;

	assign in_ready   = !valid_s1 || take;
	assign item_valid = valid_s1;
	assign item       = item_s1;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end

endmodule

FILE: rtl/sdsi_core.sv
// Init sequencer state and next-byte logic, one item per advance.
module sdsi_core import sdsi_pkg::*; #(
	parameter int unsigned RESP_BYTES = 5
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 adv,
	input  item_t                item,
	output result_t              res
);

	`include "sd_spi_init_sequencer_assert.svh"

	// phase codes: idle, warm-up, then four sub-phases per stage
	localparam logic [4:0] PH_IDLE = 5'd0;
	localparam logic [4:0] PH_WARM = 5'd1;
	localparam logic [4:0] PH_BASE = 5'd2;
	localparam logic [4:0] PH_END  = 5'd26;
	localparam logic [1:0] SUB_TX   = 2'd0;
	localparam logic [1:0] SUB_POLL = 2'd1;
	localparam logic [1:0] SUB_DATA = 2'd2;
	localparam logic [1:0] SUB_TAIL = 2'd3;
	localparam logic [3:0] WARM_BYTES = 4'd10;
	localparam logic [3:0] CMD_BYTES  = 4'd6;
	localparam logic [3:0] RESP_LEN   = 4'(RESP_BYTES);

	logic [4:0]  phase_q, phase_n;
	logic [3:0]  byte_cnt_q, byte_cnt_n;
	logic [15:0] poll_cnt_q, poll_cnt_n;
	logic [15:0] retry_cnt_q, retry_cnt_n;
	logic [2:0]  err_q, err_n;
	logic        high_q, high_n;
	logic [15:0] poll_limit_q, retry_limit_q;
	logic [7:0]  resp_q [RESP_BYTES];
	logic [7:0]  resp_rd [5];

	logic        resp_we;
	logic [2:0]  resp_wr_idx;
	logic [7:0]  resp_wr_val;

	logic [4:0]  ph_off;
	logic [2:0]  st;
	logic [1:0]  sub;
	logic [3:0]  n_len;
	logic [15:0] retry_inc;
	logic        do_begin, do_finish;
	logic [2:0]  begin_st, fin_code;
	logic [7:0]  r1;

	// response bytes beyond the stored depth read as zero
	for (genvar k = 0; k < 5; k++) begin : g_rd
		if (k < RESP_BYTES) begin : g_st
			assign resp_rd[k] = resp_q[k];
		end else begin : g_zero
			assign resp_rd[k] = 8'h00;
		end
	end

	assign ph_off    = phase_q - PH_BASE;
	assign st        = ph_off[4:2];
	assign sub       = ph_off[1:0];
	assign n_len     = (st == ST_CMD8 || st == ST_CMD58 || st == ST_FINAL) ? RESP_LEN : 4'd1;
	assign r1        = resp_rd[0];
	assign retry_inc = (retry_cnt_q != 16'hFFFF) ? retry_cnt_q + 16'd1 : retry_cnt_q;

	// next state and result
	always_comb begin
		phase_n     = phase_q;
		byte_cnt_n  = byte_cnt_q;
		poll_cnt_n  = poll_cnt_q;
		retry_cnt_n = retry_cnt_q;
		err_n       = err_q;
		high_n      = high_q;
		resp_we     = 1'b0;
		resp_wr_idx = 3'd0;
		resp_wr_val = item.rx_byte;
		do_begin    = 1'b0;
		do_finish   = 1'b0;
		begin_st    = ST_CMD0;
		fin_code    = ERR_OK;
		res.tx_byte  = IDLE_BYTE;
		res.cs_level = 1'b0;
		res.busy_res = 1'b1;
		res.done_res = 1'b0;

		priority if (item.action == ACT_START) begin
			phase_n      = PH_WARM;
			byte_cnt_n   = 4'd1;
			poll_cnt_n   = 16'd0;
			retry_cnt_n  = 16'd0;
			err_n        = ERR_OK;
			high_n       = 1'b0;
			res.cs_level = 1'b1;
		end else if (phase_q == PH_IDLE || phase_q >= PH_END) begin
			phase_n      = PH_IDLE;
			res.cs_level = 1'b1;
			res.busy_res = 1'b0;
		end else if (phase_q == PH_WARM) begin
			if (byte_cnt_q < WARM_BYTES) begin
				byte_cnt_n   = byte_cnt_q + 4'd1;
				res.cs_level = 1'b1;
			end else begin
				do_begin = 1'b1;
				begin_st = ST_CMD0;
			end
		end else begin
			unique case (sub)
				SUB_TX: begin
					if (byte_cnt_q < CMD_BYTES) begin
						res.tx_byte = cmd_byte(st, byte_cnt_q[2:0]);
						byte_cnt_n  = byte_cnt_q + 4'd1;
					end else begin
						phase_n    = {st, SUB_POLL} + PH_BASE;
						poll_cnt_n = 16'd1;
					end
				end
				SUB_POLL: begin
					if (item.rx_byte != IDLE_BYTE) begin
						resp_we = 1'b1;
						if ((item.rx_byte & 8'hFE) == 8'h00 && n_len > 4'd1) begin
							phase_n    = {st, SUB_DATA} + PH_BASE;
							byte_cnt_n = 4'd1;
						end else begin
							phase_n = {st, SUB_TAIL} + PH_BASE;
						end
					end else if (poll_cnt_q >= poll_limit_q) begin
						// timeout: R1 reads as all ones
						resp_we     = 1'b1;
						resp_wr_val = IDLE_BYTE;
						phase_n     = {st, SUB_TAIL} + PH_BASE;
					end else begin
						poll_cnt_n = poll_cnt_q + 16'd1;
					end
				end
				SUB_DATA: begin
					resp_we     = (byte_cnt_q < 4'd5);
					resp_wr_idx = byte_cnt_q[2:0];
					byte_cnt_n  = byte_cnt_q + 4'd1;
					if (byte_cnt_q + 4'd1 >= n_len) begin
						phase_n = {st, SUB_TAIL} + PH_BASE;
					end
				end
				SUB_TAIL: begin
					unique case (st)
						ST_CMD0: begin
							if (r1 != 8'h01) begin
								do_finish = 1'b1;
								fin_code  = ERR_CMD0;
							end else begin
								do_begin = 1'b1;
								begin_st = ST_CMD8;
							end
						end
						ST_CMD8: begin
							priority if (r1 == 8'h05) begin
								do_finish = 1'b1;
								fin_code  = ERR_CMD8_ILL;
							end else if (r1 != 8'h01 || resp_rd[3] != 8'h01 ||
								resp_rd[4] != 8'hAA) begin
								do_finish = 1'b1;
								fin_code  = ERR_CMD8;
							end else begin
								do_begin = 1'b1;
								begin_st = ST_CMD58;
							end
						end
						ST_CMD58: begin
							if (r1 != 8'h01 || resp_rd[2] != 8'hFF || resp_rd[3] != 8'h80) begin
								do_finish = 1'b1;
								fin_code  = ERR_CMD58;
							end else begin
								retry_cnt_n = 16'd0;
								do_begin    = 1'b1;
								begin_st    = ST_CMD55;
							end
						end
						ST_CMD55: begin
							do_begin = 1'b1;
							begin_st = ST_ACMD41;
						end
						ST_ACMD41: begin
							retry_cnt_n = retry_inc;
							priority if (r1 == 8'h00) begin
								do_begin = 1'b1;
								begin_st = ST_FINAL;
							end else if (retry_inc >= retry_limit_q) begin
								do_finish = 1'b1;
								fin_code  = ERR_TIMEOUT;
							end else begin
								do_begin = 1'b1;
								begin_st = ST_CMD55;
							end
						end
						default: begin
							// final OCR classifies capacity
							do_finish = 1'b1;
							priority if ((r1 & 8'hFE) != 8'h00) begin
								fin_code = ERR_NO_CARD;
							end else if (resp_rd[1] == 8'hC0) begin
								high_n   = 1'b1;
								fin_code = ERR_OK;
							end else if (resp_rd[1] == 8'h80) begin
								fin_code = ERR_STD_CAP;
							end else begin
								fin_code = ERR_NO_CARD;
							end
						end
					endcase
				end
				default: ;
			endcase
		end

		if (do_begin) begin
			phase_n     = {begin_st, SUB_TX} + PH_BASE;
			byte_cnt_n  = 4'd1;
			res.tx_byte = cmd_byte(begin_st, 3'd0);
		end
		if (do_finish) begin
			err_n        = fin_code;
			phase_n      = PH_IDLE;
			res.cs_level = 1'b1;
			res.busy_res = 1'b0;
			res.done_res = 1'b1;
		end

		res.error_code = res.busy_res ? ERR_OK : err_n;
		res.hi_cap     = res.busy_res ? 1'b0 : high_n;
	end

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			byte_cnt_q  <= 4'd0;
			poll_cnt_q  <= 16'd0;
			retry_cnt_q <= 16'd0;
			err_q       <= ERR_OK;
			high_q      <= 1'b0;
		end else if (adv) begin
			phase_q     <= phase_n;
			byte_cnt_q  <= byte_cnt_n;
			poll_cnt_q  <= poll_cnt_n;
			retry_cnt_q <= retry_cnt_n;
			err_q       <= err_n;
			high_q      <= high_n;
		end
	end

	// limit registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poll_limit_q  <= POLL_LIMIT_RST;
			retry_limit_q <= RETRY_LIMIT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_POLL_LIMIT:  poll_limit_q  <= cfg_data;
				default:         retry_limit_q <= cfg_data;
			endcase
		end
	end

	// response byte store
	always_ff @(posedge clk) begin
		for (int i = 0; i < RESP_BYTES; i++) begin
			if (adv && resp_we && resp_wr_idx == 3'(i)) begin
				resp_q[i] <= resp_wr_val;
			end
		end
	end

	`SDSI_ASSERT(a_phase_range, clk, arst_n, phase_q < PH_END)
	`SDSI_ASSERT(a_byte_cnt_range, clk, arst_n, byte_cnt_q <= WARM_BYTES)
	`SDSI_ASSERT_NEXT(a_done_to_idle, clk, arst_n, adv && res.done_res, phase_q == PH_IDLE)
	`SDSI_ASSERT_NEXT(a_start_warm, clk, arst_n, adv && item.action == ACT_START,
		phase_q == PH_WARM && byte_cnt_q == 4'd1)

endmodule

FILE: rtl/sdsi_out_reg.sv
// Result register: holds one result until the master side takes it.
module sdsi_out_reg import sdsi_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    load,
	input  result_t res_in,
	output logic    free,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t res_out
);

	logic    valid_q;
	result_t res_q;

	assign free      = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign res_out   = res_q;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= load;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res_in;
		end
	end

endmodule

FILE: rtl/sd_spi_init_sequencer.sv
// Top level of the SD card SPI-mode init sequencer.
//
//  channel  | dir | handshake          | payload
//  ---------+-----+--------------------+----------------------------------------
//  s_*      | in  | s_tvalid/s_tready  | tuser: action; tdata: rx_byte
//  m_*      | out | m_tvalid/m_tready  | tdata: tx_byte, cs, busy, done, err, hi_cap
//  cfg_*    | in  | cfg_we             | cfg_index, cfg_data (16 bits)
//
// One result per input beat, one beat per cycle sustained while the master
// side takes results. The path runs through the input register, then the
// next-byte logic into the result register. The state update is a single
// pass through the sequencer logic. Reset is asynchronous, clears the state
// and loads both limits with 1000. A stalled master side holds the result;
// one more beat waits in the input register, then s_tready drops.
module sd_spi_init_sequencer import sdsi_pkg::*; #(
	parameter int unsigned RESP_BYTES = 5
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [7:0]           s_tdata,   // [7:0] rx_byte
	input  logic [0:0]           s_tuser,   // [0] action
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [15:0]          m_tdata,   // [7:0] tx_byte, [8] cs_level, [9] busy_res,
	                                        // [10] done_res, [13:11] error_code,
	                                        // [14] hi_cap, [15] zero
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	item_t   in_item, item;
	result_t res, res_out;
	logic    item_valid, out_free, adv;

	assign in_item.action  = s_tuser[0];
	assign in_item.rx_byte = s_tdata;
	assign adv             = item_valid && out_free;

	sdsi_in_reg u_in (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_item    (in_item),
		.take       (adv),
		.item_valid (item_valid),
		.item       (item)
	);

	sdsi_core #(
		.RESP_BYTES (RESP_BYTES)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.adv       (adv),
		.item      (item),
		.res       (res)
	);

	sdsi_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (adv),
		.res_in    (res),
		.free      (out_free),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.res_out   (res_out)
	);

	// pack result fields, tx_byte in the lowest bits
	assign m_tdata = {1'b0, res_out.hi_cap, res_out.error_code, res_out.done_res,
		res_out.busy_res, res_out.cs_level, res_out.tx_byte};

endmodule

FILE: dv/sd_spi_init_sequencer_test.sv
// Testbench for the SD SPI init sequencer: card emulation and checks against an in-bench predictor.
`timescale 1ns / 100ps

module sd_spi_init_sequencer_test;
	import sdsi_pkg::*;

	// card response values
	localparam logic [7:0] R1_READY      = 8'h00;
	localparam logic [7:0] R1_IDLE       = 8'h01;
	localparam logic [7:0] R1_ILLEGAL    = 8'h05;
	localparam logic [7:0] R1_ERR_MASK   = 8'hFE;
	localparam logic [7:0] VHS_OK        = 8'h01;
	localparam logic [7:0] CHECK_PATTERN = 8'hAA;
	localparam logic [7:0] OCR_VOLT_ALL  = 8'hFF;
	localparam logic [7:0] OCR_POWER_UP  = 8'h80;
	localparam logic [7:0] OCR_HIGH      = 8'hC0;
	localparam logic [7:0] OCR_STD       = 8'h80;

	// command indexes
	localparam logic [7:0] IDX_GO_IDLE  = 8'd0;
	localparam logic [7:0] IDX_IF_COND  = 8'd8;
	localparam logic [7:0] IDX_APP_CMD  = 8'd55;
	localparam logic [7:0] IDX_SEND_OP  = 8'd41;
	localparam logic [7:0] IDX_READ_OCR = 8'd58;

	localparam int unsigned WARM_BYTES   = 10;
	localparam int unsigned FRAME_BYTES  = 6;
	localparam int unsigned RESP_LEN     = 5;
	localparam int unsigned RANDOM_BEATS = 300;

	typedef enum logic [1:0] {MD_IDLE, MD_WARM, MD_STAGE} seq_mode_e;
	typedef enum logic [1:0] {SB_TX, SB_POLL, SB_DATA, SB_TAIL} seq_sub_e;

	// card behavior for one init run
	typedef enum int {
		F_NONE, F_STD_CAP, F_ODD_OCR, F_FINAL_R1, F_CMD0, F_CMD8_ILL,
		F_CMD8_PAT, F_CMD58, F_ACMD_TIMEOUT, F_MUTE
	} card_fault_e;

	typedef struct {
		int unsigned poll_max;
		int unsigned busy_tries;
		logic [7:0]  r1_cmd0;
		logic [7:0]  r1_cmd8;
		logic [7:0]  r1_cmd58;
		logic [7:0]  r1_busy;
		logic [7:0]  r1_final;
		logic [7:0]  cmd8_volt;
		logic [7:0]  cmd8_check;
		logic [7:0]  ocr_b2;
		logic [7:0]  ocr_b3;
		logic [7:0]  final_ocr;
		logic        mute_on;
		logic [2:0]  mute_stage;
		int unsigned noise;
		int unsigned restart_after;
	} card_plan_t;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 s_tvalid  = 1'b0;
	logic                 s_tready;
	logic [7:0]           s_tdata   = 8'h00;
	logic [0:0]           s_tuser   = ACT_BYTE;
	logic                 m_tvalid;
	logic                 m_tready  = 1'b0;
	logic [15:0]          m_tdata;
	logic                 cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_POLL_LIMIT;
	logic [CFG_W-1:0]     cfg_data  = '0;

	logic        gaps_on = 1'b1;
	int unsigned items_sent = 0;
	int unsigned runs_done = 0;
	int unsigned results_checked = 0;
	int unsigned mismatches = 0;

	result_t queued_replies [$];

	// predictor state
	seq_mode_e   mdl_mode        = MD_IDLE;
	logic [2:0]  mdl_stage       = ST_CMD0;
	seq_sub_e    mdl_sub         = SB_TX;
	logic [3:0]  mdl_count       = '0;
	logic [15:0] mdl_polls       = '0;
	logic [15:0] mdl_retries     = '0;
	logic [15:0] mdl_poll_limit  = POLL_LIMIT_RST;
	logic [15:0] mdl_retry_limit = RETRY_LIMIT_RST;
	logic [7:0]  mdl_resp [RESP_LEN] = '{default: 8'h00};
	logic [2:0]  mdl_err         = ERR_OK;
	logic        mdl_high        = 1'b0;

	sd_spi_init_sequencer i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// ---------------------------------------------------------------- predictor

	// byte k of the six-byte command frame
	function automatic logic [7:0] frame_byte(input logic [2:0] st, input logic [3:0] k);
		logic [31:0] arg;
		logic [7:0]  idx;
		arg = 32'h0;
		case (st)
			ST_CMD0:   idx = IDX_GO_IDLE;
			ST_CMD8: begin
				idx = IDX_IF_COND;
				arg = ARG_CMD8;
			end
			ST_CMD55:  idx = IDX_APP_CMD;
			ST_ACMD41: begin
				idx = IDX_SEND_OP;
				arg = ARG_ACMD41;
			end
			default:   idx = IDX_READ_OCR;
		endcase
		if (k == 0) return CMD_START | idx;
		if (k <= 4) return arg[8*(4-k) +: 8];
		if (st == ST_CMD0) return CRC_CMD0;
		if (st == ST_CMD8) return CRC_CMD8;
		return CRC_OTHER;
	endfunction

	function automatic result_t reply(input logic [7:0] tx, input logic cs, input logic busy,
			input logic done);
		result_t r;
		r.tx_byte    = tx;
		r.cs_level   = cs;
		r.busy_res   = busy;
		r.done_res   = done;
		r.error_code = busy ? ERR_OK : mdl_err;
		r.hi_cap     = busy ? 1'b0 : mdl_high;
		return r;
	endfunction

	function automatic result_t open_stage(input logic [2:0] st);
		mdl_mode  = MD_STAGE;
		mdl_stage = st;
		mdl_sub   = SB_TX;
		mdl_count = 4'd1;
		return reply(frame_byte(st, 4'd0), 1'b0, 1'b1, 1'b0);
	endfunction

	function automatic result_t close_run(input logic [2:0] code);
		mdl_err  = code;
		mdl_mode = MD_IDLE;
		return reply(IDLE_BYTE, 1'b1, 1'b0, 1'b1);
	endfunction

	// decision taken on the beat after a response's trailing byte
	function automatic result_t judge_stage();
		logic [7:0] r1;
		r1 = mdl_resp[0];
		case (mdl_stage)
			ST_CMD0: begin
				if (r1 != R1_IDLE) return close_run(ERR_CMD0);
				return open_stage(ST_CMD8);
			end
			ST_CMD8: begin
				if (r1 == R1_ILLEGAL) return close_run(ERR_CMD8_ILL);
				if (r1 != R1_IDLE || mdl_resp[3] != VHS_OK || mdl_resp[4] != CHECK_PATTERN)
					return close_run(ERR_CMD8);
				return open_stage(ST_CMD58);
			end
			ST_CMD58: begin
				if (r1 != R1_IDLE || mdl_resp[2] != OCR_VOLT_ALL || mdl_resp[3] != OCR_POWER_UP)
					return close_run(ERR_CMD58);
				mdl_retries = '0;
				return open_stage(ST_CMD55);
			end
			ST_CMD55: return open_stage(ST_ACMD41);
			ST_ACMD41: begin
				if (mdl_retries != 16'hFFFF) mdl_retries++;
				if (r1 == R1_READY) return open_stage(ST_FINAL);
				if (mdl_retries >= mdl_retry_limit) return close_run(ERR_TIMEOUT);
				return open_stage(ST_CMD55);
			end
			default: begin
				if ((r1 & R1_ERR_MASK) != 0) return close_run(ERR_NO_CARD);
				if (mdl_resp[1] == OCR_HIGH) begin
					mdl_high = 1'b1;
					return close_run(ERR_OK);
				end
				if (mdl_resp[1] == OCR_STD) return close_run(ERR_STD_CAP);
				return close_run(ERR_NO_CARD);
			end
		endcase
	endfunction

	// expected result for one accepted input beat; advances the predictor
	function automatic result_t step_sequencer(input logic act, input logic [7:0] rx);
		int unsigned n;
		logic [7:0]  tx;
		if (act == ACT_START) begin
			mdl_mode    = MD_WARM;
			mdl_count   = 4'd1;
			mdl_polls   = '0;
			mdl_retries = '0;
			mdl_err     = ERR_OK;
			mdl_high    = 1'b0;
			return reply(IDLE_BYTE, 1'b1, 1'b1, 1'b0);
		end
		if (mdl_mode == MD_IDLE) return reply(IDLE_BYTE, 1'b1, 1'b0, 1'b0);
		if (mdl_mode == MD_WARM) begin
			if (mdl_count < WARM_BYTES) begin
				mdl_count++;
				return reply(IDLE_BYTE, 1'b1, 1'b1, 1'b0);
			end
			return open_stage(ST_CMD0);
		end
		n = (mdl_stage == ST_CMD8 || mdl_stage == ST_CMD58 || mdl_stage == ST_FINAL) ?
			RESP_LEN : 1;
		case (mdl_sub)
			SB_TX: begin
				if (mdl_count < FRAME_BYTES) begin
					tx = frame_byte(mdl_stage, mdl_count);
					mdl_count++;
					return reply(tx, 1'b0, 1'b1, 1'b0);
				end
				mdl_sub   = SB_POLL;
				mdl_polls = 16'd1;
				return reply(IDLE_BYTE, 1'b0, 1'b1, 1'b0);
			end
			SB_POLL: begin
				if (rx != IDLE_BYTE) begin
					mdl_resp[0] = rx;
					if ((rx & R1_ERR_MASK) == 0 && n > 1) begin
						mdl_sub   = SB_DATA;
						mdl_count = 4'd1;
					end else begin
						mdl_sub = SB_TAIL;
					end
				end else if (mdl_polls >= mdl_poll_limit) begin
					mdl_resp[0] = IDLE_BYTE;
					mdl_sub     = SB_TAIL;
				end else begin
					mdl_polls++;
				end
				return reply(IDLE_BYTE, 1'b0, 1'b1, 1'b0);
			end
			SB_DATA: begin
				if (mdl_count < RESP_LEN) mdl_resp[mdl_count[2:0]] = rx;
				mdl_count++;
				if (mdl_count >= n) mdl_sub = SB_TAIL;
				return reply(IDLE_BYTE, 1'b0, 1'b1, 1'b0);
			end
			default: return judge_stage();
		endcase
	endfunction

	// ---------------------------------------------------------------- card emulation

	function automatic logic [7:0] bad_r1();
		return 8'($urandom_range(254, 2));
	endfunction

	function automatic card_plan_t plan_for(input card_fault_e f);
		card_plan_t  p;
		int unsigned eff_poll;
		int unsigned eff_retry;
		logic [7:0]  v;
		eff_poll  = (mdl_poll_limit == 0) ? 1 : mdl_poll_limit;
		eff_retry = (mdl_retry_limit == 0) ? 1 : mdl_retry_limit;
		p.poll_max   = (eff_poll > 4) ? 3 : eff_poll - 1;
		p.busy_tries = $urandom_range(3);
		if (p.busy_tries >= eff_retry) p.busy_tries = eff_retry - 1;
		p.r1_cmd0    = R1_IDLE;
		p.r1_cmd8    = R1_IDLE;
		p.r1_cmd58   = R1_IDLE;
		p.r1_busy    = ($urandom_range(4) == 0) ? bad_r1() : R1_IDLE;
		p.r1_final   = $urandom_range(1) ? R1_IDLE : R1_READY;
		p.cmd8_volt  = VHS_OK;
		p.cmd8_check = CHECK_PATTERN;
		p.ocr_b2     = OCR_VOLT_ALL;
		p.ocr_b3     = OCR_POWER_UP;
		p.final_ocr  = OCR_HIGH;
		p.mute_on    = 1'b0;
		p.mute_stage = ST_CMD0;
		p.noise      = 0;
		p.restart_after = 0;
		case (f)
			F_STD_CAP: p.final_ocr = OCR_STD;
			F_ODD_OCR: begin
				v = 8'($urandom_range(255));
				if (v == OCR_HIGH || v == OCR_STD) v ^= 8'h01;
				p.final_ocr = v;
			end
			F_FINAL_R1: p.r1_final = bad_r1();
			F_CMD0:     p.r1_cmd0 = $urandom_range(1) ? R1_READY : bad_r1();
			F_CMD8_ILL: p.r1_cmd8 = R1_ILLEGAL;
			F_CMD8_PAT: begin
				case ($urandom_range(2))
					0:       p.r1_cmd8 = R1_READY;
					1:       p.cmd8_volt ^= 8'($urandom_range(255, 1));
					default: p.cmd8_check ^= 8'($urandom_range(255, 1));
				endcase
			end
			F_CMD58: begin
				case ($urandom_range(2))
					0:       p.r1_cmd58 = $urandom_range(1) ? R1_READY : bad_r1();
					1:       p.ocr_b2 ^= 8'($urandom_range(255, 1));
					default: p.ocr_b3 ^= 8'($urandom_range(255, 1));
				endcase
			end
			F_ACMD_TIMEOUT: if (eff_retry <= 8) p.busy_tries = eff_retry;
			F_MUTE: begin
				if (eff_poll <= 16) begin
					p.mute_on    = 1'b1;
					p.mute_stage = 3'($urandom_range(5));
				end
			end
			default: ;
		endcase
		return p;
	endfunction

	// byte the card returns on the next transfer, given where the sequencer stands
	function automatic logic [7:0] card_byte(input card_plan_t p);
		logic [7:0] b;
		b = 8'($urandom_range(255));
		if (mdl_mode != MD_STAGE) return b;
		if (mdl_sub == SB_POLL) begin
			if (p.mute_on && mdl_stage == p.mute_stage) return IDLE_BYTE;
			if (mdl_polls <= p.poll_max && $urandom_range(1) == 1) return IDLE_BYTE;
			case (mdl_stage)
				ST_CMD0:   return p.r1_cmd0;
				ST_CMD8:   return p.r1_cmd8;
				ST_CMD58:  return p.r1_cmd58;
				ST_CMD55: begin
					if ($urandom_range(2) == 0) return R1_READY;
					if ($urandom_range(1) == 0) return R1_IDLE;
					return bad_r1();
				end
				ST_ACMD41: return (mdl_retries < p.busy_tries) ? p.r1_busy : R1_READY;
				default:   return p.r1_final;
			endcase
		end
		if (mdl_sub == SB_DATA) begin
			if (mdl_stage == ST_CMD8 && mdl_count == 3) return p.cmd8_volt;
			if (mdl_stage == ST_CMD8 && mdl_count == 4) return p.cmd8_check;
			if (mdl_stage == ST_CMD58 && mdl_count == 2) return p.ocr_b2;
			if (mdl_stage == ST_CMD58 && mdl_count == 3) return p.ocr_b3;
			if (mdl_stage == ST_FINAL && mdl_count == 1) return p.final_ocr;
		end
		return b;
	endfunction

	// ---------------------------------------------------------------- drivers

	// send one input beat, with random idle cycles ahead of it
	task automatic send_beat(input logic act, input logic [7:0] rx);
		while (gaps_on && $urandom_range(99) < 23) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= act;
		s_tdata  <= rx;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		queued_replies.push_back(step_sequencer(act, rx));
		items_sent++;
	endtask

	// stop sending and let every expected result come back
	task automatic wait_quiet();
		int unsigned guard;
		s_tvalid <= 1'b0;
		guard = 0;
		while (queued_replies.size() != 0 && guard < 10000) begin
			@(posedge clk);
			guard++;
		end
		repeat (4) @(posedge clk);
	endtask

	task automatic program_limits(input logic [15:0] poll, input logic [15:0] retry);
		wait_quiet();
		cfg_we    <= 1'b1;
		cfg_index <= REG_POLL_LIMIT;
		cfg_data  <= poll;
		@(posedge clk);
		cfg_index <= REG_RETRY_LIMIT;
		cfg_data  <= retry;
		@(posedge clk);
		cfg_we <= 1'b0;
		mdl_poll_limit  = poll;
		mdl_retry_limit = retry;
		@(posedge clk);
	endtask

	// one init run: start, then card bytes until the sequencer reports the end
	task automatic run_card(input card_plan_t plan);
		int unsigned n_sent;
		send_beat(ACT_START, 8'($urandom_range(255)));
		n_sent = 1;
		while (mdl_mode != MD_IDLE) begin
			if (plan.restart_after != 0 && n_sent == plan.restart_after)
				send_beat(ACT_START, 8'($urandom_range(255)));
			else if ($urandom_range(99) < plan.noise)
				send_beat(($urandom_range(7) == 0) ? ACT_START : ACT_BYTE,
					8'($urandom_range(255)));
			else
				send_beat(ACT_BYTE, card_byte(plan));
			n_sent++;
		end
		runs_done++;
	endtask

	// ---------------------------------------------------------------- checking

	task automatic note_mismatch(input string msg);
		mismatches++;
		$display("MISMATCH @%0t: %s", $time, msg);
	endtask

	task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
		if (got !== want)
			note_mismatch($sformatf("result %0d %s is %0h, expected %0h",
				results_checked, name, got, want));
	endtask

	// result side: compare each beat with the oldest expectation, random back-pressure
	always @(posedge clk) begin : result_check
		result_t got;
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.tx_byte    = m_tdata[7:0];
			got.cs_level   = m_tdata[8];
			got.busy_res   = m_tdata[9];
			got.done_res   = m_tdata[10];
			got.error_code = m_tdata[13:11];
			got.hi_cap     = m_tdata[14];
			if (queued_replies.size() == 0) begin
				note_mismatch("result beat with nothing expected");
			end else begin
				want = queued_replies.pop_front();
				check_field("tx_byte", got.tx_byte, want.tx_byte);
				check_field("cs_level", 8'(got.cs_level), 8'(want.cs_level));
				check_field("busy_res", 8'(got.busy_res), 8'(want.busy_res));
				check_field("done_res", 8'(got.done_res), 8'(want.done_res));
				check_field("error_code", 8'(got.error_code), 8'(want.error_code));
				check_field("hi_cap", 8'(got.hi_cap), 8'(want.hi_cap));
				results_checked++;
			end
		end
		m_tready <= !gaps_on || ($urandom_range(99) >= 23);
	end

	// ---------------------------------------------------------------- tests

	// bytes before any start request
	task automatic test_idle_bytes();
		send_beat(ACT_BYTE, 8'h00);
		send_beat(ACT_BYTE, 8'hFF);
		send_beat(ACT_BYTE, 8'hA5);
	endtask

	// good cards at reset limits; idle bytes after repeat the outcome
	task automatic test_good_card();
		card_plan_t p;
		run_card(plan_for(F_NONE));
		send_beat(ACT_BYTE, 8'h00);
		send_beat(ACT_BYTE, 8'hFF);
		p = plan_for(F_STD_CAP);
		p.r1_final = R1_IDLE;
		run_card(p);
		send_beat(ACT_BYTE, 8'h5A);
	endtask

	// each card fault once, with small limits
	task automatic test_each_outcome();
		card_fault_e f;
		program_limits(16'd4, 16'd3);
		f = f.first();
		do begin
			run_card(plan_for(f));
			send_beat(ACT_BYTE, 8'($urandom_range(255)));
			f = f.next();
		end while (f != f.first());
	endtask

	// limits of one, zero and the maximum
	task automatic test_limit_extremes();
		program_limits(16'd1, 16'd1);
		run_card(plan_for(F_MUTE));
		run_card(plan_for(F_ACMD_TIMEOUT));
		run_card(plan_for(F_NONE));
		program_limits(16'd0, 16'd0);
		run_card(plan_for(F_MUTE));
		run_card(plan_for(F_ACMD_TIMEOUT));
		program_limits(16'hFFFF, 16'hFFFF);
		run_card(plan_for(F_NONE));
		run_card(plan_for(F_STD_CAP));
	endtask

	// start requests while a run is under way
	task automatic test_restart();
		card_plan_t p;
		program_limits(POLL_LIMIT_RST, RETRY_LIMIT_RST);
		send_beat(ACT_START, 8'h00);
		p = plan_for(F_NONE);
		p.restart_after = 30;
		run_card(p);
		p = plan_for(F_NONE);
		p.restart_after = 3;
		run_card(p);
	endtask

	// random runs over several limit settings, with noise and a stretch without gaps
	task automatic test_random_runs();
		int unsigned start_items;
		int unsigned runs_left;
		card_fault_e f;
		card_plan_t  p;
		logic [15:0] poll;
		logic [15:0] retry;
		start_items = items_sent;
		runs_left = 0;
		while (items_sent - start_items < RANDOM_BEATS) begin
			gaps_on = !(items_sent - start_items >= 40 && items_sent - start_items < 220);
			if (runs_left == 0) begin
				case ($urandom_range(3))
					0:       poll = 16'd1;
					1:       poll = 16'($urandom_range(6, 2));
					2:       poll = POLL_LIMIT_RST;
					default: poll = 16'hFFFF;
				endcase
				case ($urandom_range(2))
					0:       retry = 16'd1;
					1:       retry = 16'($urandom_range(6, 2));
					default: retry = 16'hFFFF;
				endcase
				program_limits(poll, retry);
				runs_left = $urandom_range(5, 2);
			end
			if ($urandom_range(99) < 55)
				f = ($urandom_range(2) == 0) ? F_STD_CAP : F_NONE;
			else
				f = card_fault_e'($urandom_range(F_MUTE));
			p = plan_for(f);
			if ($urandom_range(99) < 15) p.noise = $urandom_range(8, 2);
			run_card(p);
			if ($urandom_range(99) < 30)
				repeat ($urandom_range(3, 1)) send_beat(ACT_BYTE, 8'($urandom_range(255)));
			runs_left--;
		end
		gaps_on = 1'b1;
	endtask

	// ---------------------------------------------------------------- sequence

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_idle_bytes();
		test_good_card();
		test_each_outcome();
		test_limit_extremes();
		test_restart();
		test_random_runs();
		wait_quiet();
		if (queued_replies.size() != 0)
			note_mismatch($sformatf("%0d expected results never came", queued_replies.size()));
		$display("Ran %0d init sequences over %0d input beats; %0d result beats checked.",
			runs_done, items_sent, results_checked);
		$display("Covered all outcome codes, poll and retry timeouts, restarts, limits 0 to 65535.");
		if (mismatches == 0) begin
			$display("** sd_spi_init_sequencer: PASSED **");
		end else begin
			$display("** sd_spi_init_sequencer: FAILED **");
		end
		$finish;
	end

	// watchdog
	initial begin
		#2_000_000;
		$display("Timeout: the run did not finish.");
		$display("** sd_spi_init_sequencer: FAILED **");
		$finish;
	end

endmodule
